FILE: design/teadec_pkg.sv
`default_nettype none

package teadec_pkg;

	localparam int WORD_W = 32;

	typedef logic [WORD_W-1:0] word_t;

	// Word pair on its way through the half-round chain. The word that the
	// next cell updates rides in upd, the word that feeds its mix in src.
	typedef struct packed {
		word_t upd;
		word_t src;
		word_t sum;
	} stage_t;

	typedef struct packed {
		word_t lo;
		word_t hi;
	} result_t;

endpackage

`default_nettype wire

FILE: design/teadec_cell.sv
`default_nettype none

module teadec_cell #(
	parameter bit SUM_STEP = 1'b0
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 in_valid,
	input  teadec_pkg::stage_t  in_data,
	input  teadec_pkg::word_t   delta,
	input  teadec_pkg::word_t   ka,
	input  teadec_pkg::word_t   kb,
	output logic                out_valid,
	output teadec_pkg::stage_t  out_data
);
	import teadec_pkg::*;

	word_t  mix_a;
	word_t  mix_b;
	word_t  mix_c;
	word_t  upd_new;
	stage_t nxt;
	logic   valid_s1;
	stage_t data_s1;

	always_comb begin
		mix_a   = (in_data.src << 4) + ka;
		mix_b   = in_data.src + in_data.sum;
		mix_c   = (in_data.src >> 5) + kb;
		upd_new = in_data.upd - (mix_a ^ mix_b ^ mix_c);
		// The freshly updated word becomes the source of the next half round.
		nxt.upd = in_data.src;
		nxt.src = upd_new;
		nxt.sum = SUM_STEP ? (in_data.sum - delta) : in_data.sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

FILE: design/teadec_skid.sv
`default_nettype none

module teadec_skid (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  teadec_pkg::result_t  in_data,
	input  wire                  stall,
	output logic                 out_valid,
	output teadec_pkg::result_t  out_data,
	output logic                 full
);
	import teadec_pkg::*;

	logic    out_valid_q;
	result_t out_data_q;
	logic    skid_valid_q;
	result_t skid_data_q;
	logic    out_free;

	// The upstream chain only moves while the skid slot is empty, so a
	// result offered here is consumed exactly when in_valid and not full.
	assign out_free = !out_valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_valid;
			skid_valid_q <= 1'b0;
		end else if (in_valid && !skid_valid_q) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && !skid_valid_q) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign full      = skid_valid_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot holds a result while the output register is empty");

	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && stall))
		else $error("skid slot filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !stall |=> !skid_valid_q && out_valid_q)
		else $error("skid slot did not drain into the output register");

endmodule

`default_nettype wire

FILE: design/tea_block_decrypt_top.sv
`default_nettype none

// TEA block decryption, one half round per cell in a chain of 2*ROUNDS cells.
// Throughput: one block per cycle; the chain plus a two-entry output buffer
// keeps accepting while a result waits, and stalls input only when that buffer is full.
// Reset (arst_n, asynchronous, active low) empties the chain and the output
// buffer and loads the key, delta and start sum registers with their defaults.
module tea_block_decrypt_top #(
	parameter int ROUNDS = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [2:0]         cfg_index,
	input  teadec_pkg::word_t  cfg_data,
	input  wire                in_valid,
	output logic               in_stall,
	input  teadec_pkg::word_t  cipher_low,
	input  teadec_pkg::word_t  cipher_high,
	output logic               out_valid,
	input  wire                out_stall,
	output teadec_pkg::word_t  plain_low,
	output teadec_pkg::word_t  plain_high
);
	import teadec_pkg::*;

	localparam int CELLS = 2 * ROUNDS;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_DELTA = 3'd4;
	localparam logic [2:0] REG_START = 3'd5;

	localparam word_t KEY0_RST  = 32'hE4FB_BDD9;
	localparam word_t KEY1_RST  = 32'hF6B9_83FD;
	localparam word_t KEY2_RST  = 32'h7102_1053;
	localparam word_t KEY3_RST  = 32'h2742_8645;
	localparam word_t DELTA_RST = 32'hDC69_1A7F;
	localparam word_t START_RST = 32'h8D23_4FE0;

	word_t key0_q;
	word_t key1_q;
	word_t key2_q;
	word_t key3_q;
	word_t delta_q;
	word_t start_q;

	stage_t  chain_d [0:CELLS];
	logic    chain_v [0:CELLS];
	logic    en;
	logic    buf_full;
	result_t res;
	result_t out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q  <= KEY0_RST;
			key1_q  <= KEY1_RST;
			key2_q  <= KEY2_RST;
			key3_q  <= KEY3_RST;
			delta_q <= DELTA_RST;
			start_q <= START_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY0:  key0_q  <= cfg_data;
				REG_KEY1:  key1_q  <= cfg_data;
				REG_KEY2:  key2_q  <= cfg_data;
				REG_KEY3:  key3_q  <= cfg_data;
				REG_DELTA: delta_q <= cfg_data;
				REG_START: start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !buf_full;
	assign in_stall = buf_full;

	// The first half round updates the high word from the low word.
	assign chain_v[0]     = in_valid;
	assign chain_d[0].upd = cipher_high;
	assign chain_d[0].src = cipher_low;
	assign chain_d[0].sum = start_q;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i % 2 == 0) begin : g_first_half
			teadec_cell #(.SUM_STEP(1'b0)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (chain_v[i]),
				.in_data   (chain_d[i]),
				.delta     (delta_q),
				.ka        (key2_q),
				.kb        (key3_q),
				.out_valid (chain_v[i+1]),
				.out_data  (chain_d[i+1])
			);
		end else begin : g_second_half
			teadec_cell #(.SUM_STEP(1'b1)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (chain_v[i]),
				.in_data   (chain_d[i]),
				.delta     (delta_q),
				.ka        (key0_q),
				.kb        (key1_q),
				.out_valid (chain_v[i+1]),
				.out_data  (chain_d[i+1])
			);
		end
	end

	// After a whole number of rounds the low word sits in src again.
	assign res.lo = chain_d[CELLS].src;
	assign res.hi = chain_d[CELLS].upd;

	teadec_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_v[CELLS]),
		.in_data   (res),
		.stall     (out_stall),
		.out_valid (out_valid),
		.out_data  (out_res),
		.full      (buf_full)
	);

	assign plain_low  = out_res.lo;
	assign plain_high = out_res.hi;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import teadec_pkg::*;

	localparam int ROUNDS     = 32;
	localparam int IDLE_LIMIT = 4000;

	localparam word_t KEY_0_DEFAULT      = 32'hE4FB_BDD9;
	localparam word_t KEY_1_DEFAULT      = 32'hF6B9_83FD;
	localparam word_t KEY_2_DEFAULT      = 32'h7102_1053;
	localparam word_t KEY_3_DEFAULT      = 32'h2742_8645;
	localparam word_t DELTA_DEFAULT      = 32'hDC69_1A7F;
	localparam word_t START_SUM_DEFAULT  = 32'h8D23_4FE0;

	typedef enum logic [2:0] {
		REG_KEY_0,
		REG_KEY_1,
		REG_KEY_2,
		REG_KEY_3,
		REG_DELTA,
		REG_START_SUM,
		REG_SPARE_6,
		REG_SPARE_7
	} reg_idx_e;

	// Holds a copy of the key, delta and start sum registers and the plaintext blocks still owed by the block.
	class tea_scoreboard;
		word_t   key [4];
		word_t   delta;
		word_t   sum_init;
		result_t plain_q [$];
		int      errors;

		function new();
			key[0]   = KEY_0_DEFAULT;
			key[1]   = KEY_1_DEFAULT;
			key[2]   = KEY_2_DEFAULT;
			key[3]   = KEY_3_DEFAULT;
			delta    = DELTA_DEFAULT;
			sum_init = START_SUM_DEFAULT;
			errors   = 0;
		endfunction

		function void write_reg(reg_idx_e idx, word_t val);
			case (idx)
				REG_KEY_0:     key[0] = val;
				REG_KEY_1:     key[1] = val;
				REG_KEY_2:     key[2] = val;
				REG_KEY_3:     key[3] = val;
				REG_DELTA:     delta = val;
				REG_START_SUM: sum_init = val;
				default: ;
			endcase
		endfunction

		function word_t tea_mix(word_t w, word_t s, word_t ka, word_t kb);
			word_t a;
			word_t b;
			word_t c;
			a = (w << 4) + ka;
			b = w + s;
			c = (w >> 5) + kb;
			return a ^ b ^ c;
		endfunction

		function result_t decrypt_block(word_t lo, word_t hi);
			result_t r;
			word_t   s;
			s = sum_init;
			for (int i = 0; i < ROUNDS; i++) begin
				hi = hi - tea_mix(lo, s, key[2], key[3]);
				lo = lo - tea_mix(hi, s, key[0], key[1]);
				s  = s - delta;
			end
			r.lo = lo;
			r.hi = hi;
			return r;
		endfunction

		function void note_cipher(word_t lo, word_t hi);
			plain_q.push_back(decrypt_block(lo, hi));
		endfunction

		function void check_plain(word_t lo, word_t hi);
			result_t exp_r;
			if (plain_q.size() == 0) begin
				$display("%0t: unexpected result lo=%h hi=%h", $time, lo, hi);
				errors++;
				return;
			end
			exp_r = plain_q.pop_front();
			if (lo !== exp_r.lo) begin
				$display("%0t: plain_low mismatch: expected %h, got %h", $time, exp_r.lo, lo);
				errors++;
			end
			if (hi !== exp_r.hi) begin
				$display("%0t: plain_high mismatch: expected %h, got %h", $time, exp_r.hi, hi);
				errors++;
			end
		endfunction

		function int pending();
			return plain_q.size();
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n;
	logic     cfg_valid;
	logic     cfg_ready;
	logic [2:0] cfg_index;
	word_t    cfg_data;
	logic     in_valid;
	logic     in_stall;
	word_t    cipher_low;
	word_t    cipher_high;
	logic     out_valid;
	logic     out_stall;
	word_t    plain_low;
	word_t    plain_high;

	tea_scoreboard sb;
	bit            burst;
	int            idle_cycles;

	tea_block_decrypt_top #(
		.ROUNDS(ROUNDS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cipher_low (cipher_low),
		.cipher_high(cipher_high),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.plain_low  (plain_low),
		.plain_high (plain_high)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every transaction on the three channels is picked up here, at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(reg_idx_e'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				sb.note_cipher(cipher_low, cipher_high);
			if (out_valid && !out_stall)
				sb.check_plain(plain_low, plain_high);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
				$display("** tea_block_decrypt_top: FAILED **");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic word_t pick_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom();
	endfunction

	// Result side: outside burst phases, stall runs alternate with free-running stretches, some of them long.
	initial begin
		int run;
		int len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (burst) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
				len = pick_gap();
				if (len > 0) begin
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
				end
			end
		end
	end

	task automatic send_block(input word_t lo, input word_t hi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cipher_low  <= lo;
		cipher_high <= hi;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drops input valid and waits until the block has returned every outstanding result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic cfg_put(input reg_idx_e idx, input word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input word_t k0, input word_t k1, input word_t k2,
			input word_t k3, input word_t dlt, input word_t sum);
		cfg_put(REG_KEY_0, k0);
		cfg_put(REG_KEY_1, k1);
		cfg_put(REG_KEY_2, k2);
		cfg_put(REG_KEY_3, k3);
		cfg_put(REG_DELTA, dlt);
		cfg_put(REG_START_SUM, sum);
		// Writes to the unused indexes must leave the key registers alone.
		cfg_put($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, $urandom());
		cfg_valid <= 1'b0;
	endtask

	initial begin
		word_t dlt;
		word_t sum;

		sb          = new();
		burst       = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = REG_KEY_0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		cipher_low  = '0;
		cipher_high = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults straight out of reset, with extreme and alternating words.
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'h0000_0000, 32'hFFFF_FFFF);
		send_block(32'hFFFF_FFFF, 32'h0000_0000);
		send_block(32'h0000_0001, 32'h0000_0000);
		send_block(32'h0000_0000, 32'h0000_0001);
		send_block(32'h8000_0000, 32'h8000_0000);
		send_block(32'hAAAA_AAAA, 32'h5555_5555);

		wait_idle();
		configure('0, '0, '0, '0, '0, '0);
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'h1234_5678, 32'h9ABC_DEF0);
		send_block(32'h5555_5555, 32'hAAAA_AAAA);

		// All-ones delta gives a start sum that is not delta times the round count.
		wait_idle();
		configure('1, '1, '1, '1, '1, '1);
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'hFFFF_FFFF, 32'h0000_0000);
		send_block(32'h0F0F_0F0F, 32'hF0F0_F0F0);

		wait_idle();
		configure(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210,
			32'h9E37_79B9, 32'hC6EF_3720);
		send_block(32'h0000_0000, 32'h0000_0000);
		send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_block(32'hDEAD_BEEF, 32'hCAFE_BABE);
		send_block(32'h0000_0001, 32'h8000_0000);

		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			dlt = pick_word();
			sum = ($urandom_range(0, 3) == 0) ? pick_word() : word_t'(dlt * ROUNDS);
			configure(pick_word(), pick_word(), pick_word(), pick_word(), dlt, sum);
			burst = (phase == 2);
			for (int i = 0; i < 90; i++) begin
				send_block(pick_word(), pick_word());
				if (phase == 1 && i == 45)
					wait_idle();
			end
			burst = 1'b0;
		end

		wait_idle();
		repeat (2 * ROUNDS + 10) @(posedge clk);

		if (sb.pending() != 0)
			$display("%0t: %0d expected blocks never came out", $time, sb.pending());
		if (sb.errors == 0 && sb.pending() == 0)
			$display("** tea_block_decrypt_top: PASSED **");
		else
			$display("** tea_block_decrypt_top: FAILED **");
		$finish;
	end

endmodule
